// ===== sv/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg: shared types, constants and helpers for the TRS model matrix block
// Q30 trig values, CORDIC arctangent table, fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package trs_pkg;
    localparam int FRACTION_BITS = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int STEPS_PER_STAGE = 4;
    localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int QW = 34;      // Q30 trig / rotation value width
    localparam int ZW = 20;      // Q16 angle accumulator width
    localparam logic signed [QW-1:0] CORDIC_K = QW'(652032874);
    localparam logic signed [ZW-1:0] PI_Q16 = ZW'(205887);
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
    localparam logic [1:0] ROW_LAST = 2'd3;
    localparam logic [31:0] ONE_FIX = 32'(1) << FRACTION_BITS;

    typedef logic signed [QW-1:0] t_q30;
    typedef logic signed [ZW-1:0] t_zq;
    typedef logic signed [31:0] t_fix;

    typedef struct packed {
        t_fix tx;
        t_fix ty;
        t_fix tz;
        t_fix sx;
        t_fix sy;
        t_fix sz;
    } t_side;

    typedef struct packed {
        t_fix c0;
        t_fix c1;
        t_fix c2;
        t_fix c3;
    } t_row;

    function automatic t_zq atan_q16(input int idx);
        t_zq v;
        case (idx)
            0: v = ZW'(51472);
            1: v = ZW'(30386);
            2: v = ZW'(16055);
            3: v = ZW'(8150);
            4: v = ZW'(4091);
            5: v = ZW'(2047);
            6: v = ZW'(1024);
            7: v = ZW'(512);
            8: v = ZW'(256);
            9: v = ZW'(128);
            10: v = ZW'(64);
            11: v = ZW'(32);
            12: v = ZW'(16);
            13: v = ZW'(8);
            14: v = ZW'(4);
            15: v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    // floor((a*b) / 2^30)
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b);
        return p[QW+29:30];
    endfunction
endpackage
`default_nettype wire

// ===== sv/trs_cordic.sv =====
// ----------------------------------------------------------------------------
// trs_cordic: pipelined sine/cosine lane
// Quadrant fold, then four register stages of four rotation steps each.
// ----------------------------------------------------------------------------
`default_nettype none
module trs_cordic (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [15:0]   i_angle,
    output trs_pkg::t_q30             o_cos,
    output trs_pkg::t_q30             o_sin
);
    localparam int NS = trs_pkg::CORDIC_STAGES;
    localparam int SP = trs_pkg::STEPS_PER_STAGE;

    trs_pkg::t_q30 r_x [0:NS];
    trs_pkg::t_q30 r_y [0:NS];
    trs_pkg::t_zq  r_z [0:NS-1];
    logic          r_flip [0:NS-1];
    trs_pkg::t_zq  n_z0;
    logic          n_flip0;
    trs_pkg::t_q30 n_x [1:NS];
    trs_pkg::t_q30 n_y [1:NS];
    trs_pkg::t_zq  n_z [1:NS-1];

    always_comb begin
        trs_pkg::t_zq za;
        za = trs_pkg::t_zq'(i_angle) <<< 3;
        n_z0 = za;
        n_flip0 = 1'b0;
        if (za > trs_pkg::HALF_PI_Q16) begin
            n_z0 = za - trs_pkg::PI_Q16;
            n_flip0 = 1'b1;
        end else if (za < -trs_pkg::HALF_PI_Q16) begin
            n_z0 = za + trs_pkg::PI_Q16;
            n_flip0 = 1'b1;
        end
    end

    always_comb begin
        trs_pkg::t_q30 x, y, dx, dy;
        trs_pkg::t_zq z;
        for (int s = 1; s <= NS; s++) begin
            x = r_x[s-1];
            y = r_y[s-1];
            z = r_z[s-1];
            for (int k = 0; k < SP; k++) begin
                dx = y >>> ((s - 1) * SP + k);
                dy = x >>> ((s - 1) * SP + k);
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - trs_pkg::atan_q16((s - 1) * SP + k);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + trs_pkg::atan_q16((s - 1) * SP + k);
                end
            end
            // fold back the half turn on the final stage
            if (s == NS && r_flip[s-1]) begin
                x = -x;
                y = -y;
            end
            n_x[s] = x;
            n_y[s] = y;
            if (s < NS) begin
                n_z[s] = z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= trs_pkg::CORDIC_K;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_flip[0] <= n_flip0;
            for (int s = 1; s <= NS; s++) begin
                r_x[s] <= n_x[s];
                r_y[s] <= n_y[s];
                if (s < NS) begin
                    r_z[s] <= n_z[s];
                    r_flip[s] <= r_flip[s-1];
                end
            end
        end
    end

    assign o_cos = r_x[NS];
    assign o_sin = r_y[NS];
endmodule
`default_nettype wire

// ===== sv/trs_rot.sv =====
// ----------------------------------------------------------------------------
// trs_rot: rotation products, scaling, rounding and saturation
// Five register stages from sine/cosine to the saturated upper 3x3.
// ----------------------------------------------------------------------------
`default_nettype none
module trs_rot (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire trs_pkg::t_side    i_side,
    input  wire trs_pkg::t_q30     i_cx,
    input  wire trs_pkg::t_q30     i_sx,
    input  wire trs_pkg::t_q30     i_cy,
    input  wire trs_pkg::t_q30     i_sy,
    input  wire trs_pkg::t_q30     i_cz,
    input  wire trs_pkg::t_q30     i_sz,
    output logic                   o_valid,
    output trs_pkg::t_side         o_side,
    output trs_pkg::t_fix          o_m [0:8]
);
    localparam int PW = trs_pkg::QW + 32;

    logic           r_v [0:4];
    trs_pkg::t_side r_sd [0:4];
    // stage A
    trs_pkg::t_q30 r_sxsz, r_sxcz, r_cycz, r_cysz, r_sycx, r_cxsz, r_cxcz;
    trs_pkg::t_q30 r_sycz, r_sysz, r_cycx, r_a_sy, r_a_cy, r_a_sx;
    // stage B
    trs_pkg::t_q30 r_sysxsz, r_sysxcz, r_cysxsz, r_cysxcz;
    trs_pkg::t_q30 r_b_cycz, r_b_cysz, r_b_sycx, r_b_cxsz, r_b_cxcz;
    trs_pkg::t_q30 r_b_sycz, r_b_sysz, r_b_cycx, r_b_sx;
    // stage C
    trs_pkg::t_q30 r_r [0:8];
    // stages D and E
    logic signed [PW-1:0] r_p [0:8];
    trs_pkg::t_fix r_o [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 5; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
            for (int k = 1; k < 5; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_sxsz <= trs_pkg::mul30(i_sx, i_sz);
            r_sxcz <= trs_pkg::mul30(i_sx, i_cz);
            r_cycz <= trs_pkg::mul30(i_cy, i_cz);
            r_cysz <= trs_pkg::mul30(i_cy, i_sz);
            r_sycx <= trs_pkg::mul30(i_sy, i_cx);
            r_cxsz <= trs_pkg::mul30(i_cx, i_sz);
            r_cxcz <= trs_pkg::mul30(i_cx, i_cz);
            r_sycz <= trs_pkg::mul30(i_sy, i_cz);
            r_sysz <= trs_pkg::mul30(i_sy, i_sz);
            r_cycx <= trs_pkg::mul30(i_cy, i_cx);
            r_a_sy <= i_sy;
            r_a_cy <= i_cy;
            r_a_sx <= i_sx;

            r_sysxsz <= trs_pkg::mul30(r_a_sy, r_sxsz);
            r_sysxcz <= trs_pkg::mul30(r_a_sy, r_sxcz);
            r_cysxsz <= trs_pkg::mul30(r_a_cy, r_sxsz);
            r_cysxcz <= trs_pkg::mul30(r_a_cy, r_sxcz);
            r_b_cycz <= r_cycz;
            r_b_cysz <= r_cysz;
            r_b_sycx <= r_sycx;
            r_b_cxsz <= r_cxsz;
            r_b_cxcz <= r_cxcz;
            r_b_sycz <= r_sycz;
            r_b_sysz <= r_sysz;
            r_b_cycx <= r_cycx;
            r_b_sx <= r_a_sx;

            r_r[0] <= r_b_cycz + r_sysxsz;
            r_r[1] <= r_sysxcz - r_b_cysz;
            r_r[2] <= r_b_sycx;
            r_r[3] <= r_b_cxsz;
            r_r[4] <= r_b_cxcz;
            r_r[5] <= -r_b_sx;
            r_r[6] <= r_cysxsz - r_b_sycz;
            r_r[7] <= r_b_sysz + r_cysxcz;
            r_r[8] <= r_b_cycx;

            for (int k = 0; k < 9; k++) begin
                case (k % 3)
                    0: r_p[k] <= PW'(r_r[k]) * PW'(r_sd[2].sx);
                    1: r_p[k] <= PW'(r_r[k]) * PW'(r_sd[2].sy);
                    default: r_p[k] <= PW'(r_r[k]) * PW'(r_sd[2].sz);
                endcase
            end

            for (int k = 0; k < 9; k++) begin
                logic signed [PW-1:0] q;
                logic signed [PW-31:0] v;
                q = r_p[k] + (PW'(1) <<< 29);
                v = q[PW-1:30];
                if (v > (PW-30)'(32'sh7FFFFFFF)) begin
                    r_o[k] <= 32'sh7FFFFFFF;
                end else if (v < (PW-30)'(-33'sh80000000)) begin
                    r_o[k] <= 32'sh80000000;
                end else begin
                    r_o[k] <= v[31:0];
                end
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_side = r_sd[4];
    assign o_m = r_o;
endmodule
`default_nettype wire

// ===== sv/trs_ser.sv =====
// ----------------------------------------------------------------------------
// trs_ser: row serializer
// Holds one finished matrix and sends it as four row transfers.
// ----------------------------------------------------------------------------
`default_nettype none
module trs_ser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire trs_pkg::t_side    i_side,
    input  wire trs_pkg::t_fix     i_m [0:8],
    output logic                   o_en,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [127:0]           o_m_tdata,
    output logic [1:0]             o_m_tuser,
    output logic                   o_m_tlast
);
    logic          r_busy;
    logic [1:0]    r_row;
    trs_pkg::t_row r_rows [0:2];
    logic          w_acc, w_load;
    trs_pkg::t_row w_out;

    assign w_acc = r_busy && i_m_tready;
    assign w_load = i_valid && (!r_busy || (w_acc && r_row == trs_pkg::ROW_LAST));
    assign o_en = !i_valid || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_row <= '0;
        end else if (w_acc) begin
            r_busy <= r_row != trs_pkg::ROW_LAST;
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rows[0] <= '{i_m[0], i_m[1], i_m[2], i_side.tx};
            r_rows[1] <= '{i_m[3], i_m[4], i_m[5], i_side.ty};
            r_rows[2] <= '{i_m[6], i_m[7], i_m[8], i_side.tz};
        end
    end

    always_comb begin
        case (r_row)
            2'd0: w_out = r_rows[0];
            2'd1: w_out = r_rows[1];
            2'd2: w_out = r_rows[2];
            default: w_out = '{32'd0, 32'd0, 32'd0, trs_pkg::ONE_FIX};
        endcase
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tdata = {w_out.c3, w_out.c2, w_out.c1, w_out.c0};
    assign o_m_tuser = r_row;
    assign o_m_tlast = r_row == trs_pkg::ROW_LAST;

    a_next_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && r_row != trs_pkg::ROW_LAST |=> r_busy && r_row == $past(r_row) + 2'd1)
        else $error("row sequence broken");
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_row == trs_pkg::ROW_LAST && !i_m_tready |=>
        r_busy && r_row == trs_pkg::ROW_LAST)
        else $error("last row dropped");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && r_busy |-> w_acc && o_m_tlast)
        else $error("matrix overwritten before sent");
endmodule
`default_nettype wire

// ===== sv/trs_model_matrix_top.sv =====
// ----------------------------------------------------------------------------
// trs_model_matrix_top: TRS model matrix, rotation order Ry*Rx*Rz
// Three CORDIC lanes, product/scale pipeline and a row serializer.
// ----------------------------------------------------------------------------
// channel  dir  signals              payload
// s        in   i_s_tvalid/o_s_tready 240b tdata: translation, angles, scales
// m        out  o_m_tvalid/i_m_tready 128b tdata rows, tuser row, tlast
//
// Four row transfers per item; the serializer takes the next matrix while idle
// or as the last row is taken. 5 CORDIC, then 5 product stages, then row 0.
// One global enable moves the pipeline; it stops only when a finished
// matrix waits and the serializer is still sending the previous one.
// Synchronous active-low reset clears valid bits and serializer state.
// ----------------------------------------------------------------------------
`default_nettype none
module trs_model_matrix_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: trans_x, trans_y, trans_z, angle_x, angle_y, angle_z,
    //        scale_x, scale_y, scale_z
    input  wire logic [239:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: col_zero, col_one, col_two, col_three
    output logic [127:0]      o_m_tdata,
    // tuser: row_index
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast
);
    localparam int CL = trs_pkg::CORDIC_STAGES + 1;

    logic           w_en;
    logic           r_v [0:CL-1];
    trs_pkg::t_side r_sd [0:CL-1];
    trs_pkg::t_side w_side_in;
    trs_pkg::t_q30  w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    logic           w_rv;
    trs_pkg::t_side w_rside;
    trs_pkg::t_fix  w_m [0:8];

    assign o_s_tready = w_en;
    assign w_side_in = '{i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[95:64],
                         i_s_tdata[175:144], i_s_tdata[207:176], i_s_tdata[239:208]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CL; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= i_s_tvalid;
            for (int k = 1; k < CL; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= w_side_in;
            for (int k = 1; k < CL; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    trs_cordic u_cx (.i_clk(i_clk), .i_en(w_en), .i_angle(i_s_tdata[111:96]),
                     .o_cos(w_cx), .o_sin(w_sx));
    trs_cordic u_cy (.i_clk(i_clk), .i_en(w_en), .i_angle(i_s_tdata[127:112]),
                     .o_cos(w_cy), .o_sin(w_sy));
    trs_cordic u_cz (.i_clk(i_clk), .i_en(w_en), .i_angle(i_s_tdata[143:128]),
                     .o_cos(w_cz), .o_sin(w_sz));

    trs_rot u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r_v[CL-1]), .i_side(r_sd[CL-1]),
        .i_cx(w_cx), .i_sx(w_sx), .i_cy(w_cy), .i_sy(w_sy), .i_cz(w_cz), .i_sz(w_sz),
        .o_valid(w_rv), .o_side(w_rside), .o_m(w_m)
    );

    trs_ser u_ser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_rv), .i_side(w_rside),
        .i_m(w_m), .o_en(w_en), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for trs_model_matrix_top
// Streams transforms into the block. The sender and the receiver pause at
// random. Each transform is turned into four expected matrix rows, and every
// row that comes out is compared field by field against them.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM = 440;

    typedef struct packed {
        logic [31:0] c3;
        logic [31:0] c2;
        logic [31:0] c1;
        logic [31:0] c0;
        logic [1:0]  row;
        logic        last;
    } t_exp_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [239:0] i_s_tdata;    // trans_x, trans_y, trans_z, angle_x, angle_y,
                                // angle_z, scale_x, scale_y, scale_z
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [127:0] o_m_tdata;    // col_zero, col_one, col_two, col_three
    logic [1:0]   o_m_tuser;    // row_index
    logic         o_m_tlast;

    logic [239:0] pending_items[$];
    t_exp_row     rows_due[$];
    int           errors = 0;
    int           rows_seen = 0;
    int           items_sent = 0;
    int           cycles = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           hold_off = 0;
    bit           stim_done = 0;

    trs_model_matrix_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_row(input t_exp_row e);
        rows_due = {rows_due, e};
    endfunction

    function automatic void add_item(input logic [239:0] d);
        pending_items = {pending_items, d};
    endfunction

    // floor shift of a 64-bit signed value
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return floor_shr(a * b, 30);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] scale_entry(input longint r, input longint s);
        return clamp32(floor_shr(r * s + (64'sd1 <<< 29), 30));
    endfunction

    function automatic void trig(input logic signed [15:0] ang,
                                 output longint c, output longint s);
        longint z, x, y, dx, dy;
        longint atab[16];
        bit flip;
        atab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                 256, 128, 64, 32, 16, 8, 4, 2};
        z = longint'(ang) * 8;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 102944) begin
            z -= 205887;
            flip = 1;
        end else if (z < -102944) begin
            z += 205887;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atab[i];
            end else begin
                x += dx; y -= dy; z += atab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void predict_matrix(input logic [239:0] d);
        longint cx, sx, cy, sy, cz, sz, sxsz, sxcz;
        longint r[3][3];
        longint sc[3];
        t_exp_row e;
        trig(d[111:96], cx, sx);
        trig(d[127:112], cy, sy);
        trig(d[143:128], cz, sz);
        for (int j = 0; j < 3; j++) sc[j] = longint'($signed(d[144+32*j +: 32]));
        sxsz = qmul(sx, sz);
        sxcz = qmul(sx, cz);
        r[0][0] = qmul(cy, cz) + qmul(sy, sxsz);
        r[0][1] = qmul(sy, sxcz) - qmul(cy, sz);
        r[0][2] = qmul(sy, cx);
        r[1][0] = qmul(cx, sz);
        r[1][1] = qmul(cx, cz);
        r[1][2] = -sx;
        r[2][0] = qmul(cy, sxsz) - qmul(sy, cz);
        r[2][1] = qmul(sy, sz) + qmul(cy, sxcz);
        r[2][2] = qmul(cy, cx);
        for (int k = 0; k < 3; k++) begin
            e.row = 2'(k);
            e.c0 = scale_entry(r[k][0], sc[0]);
            e.c1 = scale_entry(r[k][1], sc[1]);
            e.c2 = scale_entry(r[k][2], sc[2]);
            e.c3 = d[32*k +: 32];
            e.last = 1'b0;
            add_row(e);
        end
        e = '{c3: trs_pkg::ONE_FIX, c2: '0, c1: '0, c0: '0, row: trs_pkg::ROW_LAST,
              last: 1'b1};
        add_row(e);
    endfunction

    function automatic logic [239:0] pack_item(input logic [31:0] tx, ty, tz,
                                               input logic [15:0] ax, ay, az,
                                               input logic [31:0] kx, ky, kz);
        return {kz, ky, kx, az, ay, ax, tz, ty, tx};
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'(25736 - $urandom_range(0, 40));
            1: return 16'(-25736 + $urandom_range(0, 40));
            2: return 16'($urandom_range(12800, 12900));
            3: return 16'(-$urandom_range(12800, 12900));
            default: return 16'($urandom_range(0, 51472) - 25736);
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0004_0000)) ^ {32{$urandom_range(0, 1) == 1}};
            default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("row %0d: %s got %h expected %h", rows_seen, what, got, want);
    endtask

    initial begin
        logic [15:0] angs[7];
        angs = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                 16'sd12869, -16'sd12869};
        i_rst_n = 1'b0;
        foreach (angs[a])
            add_item(pack_item(32'h7FFF_FFFF, 32'h8000_0000, $urandom,
                angs[a], angs[(a + 3) % 7], angs[(a + 5) % 7],
                32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000));
        add_item(pack_item(0, 0, 0, '0, '0, '0,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_item(pack_item(32'hFFFF_FFFF, 0, 32'h8000_0000, '0, '0, '0,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_item(pack_item(1, 2, 3, 16'sd25736, 16'sd25736, 16'sd25736,
            32'h8000_0000, 32'h7FFF_FFFF, 0));
        add_item(pack_item(0, 0, 0, 16'sd6434, -16'sd6434, 16'sd3000,
            32'hFFFF_FFFF, 1, 32'h4000_0000));
        for (int n = 0; n < N_RANDOM; n++)
            add_item(pack_item($urandom, $urandom, $urandom,
                rand_angle(), rand_angle(), rand_angle(),
                rand_scale(), rand_scale(), rand_scale()));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
            send_gap <= $urandom_range(0, 19);
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_matrix(i_s_tdata);
                items_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0 || pending_items.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= pending_items.pop_front();
                    // stretches of back-to-back transfers
                    send_gap <= (items_sent % 100 < 40) ? 0 : $urandom_range(0, 19);
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps streaming
    always @(posedge i_clk) begin
        if (!i_rst_n) hold_off <= 0;
        else if (items_sent >= 60 && hold_off == 0) hold_off <= 300;
        else if (hold_off > 1) hold_off <= hold_off - 1;
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_exp_row e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (rows_due.size() == 0) begin
                    report("unexpected transfer", o_m_tdata[31:0], '0);
                end else begin
                    e = rows_due.pop_front();
                    if (o_m_tuser !== e.row) report("row_index", 32'(o_m_tuser), 32'(e.row));
                    if (o_m_tdata[31:0] !== e.c0) report("col_zero", o_m_tdata[31:0], e.c0);
                    if (o_m_tdata[63:32] !== e.c1) report("col_one", o_m_tdata[63:32], e.c1);
                    if (o_m_tdata[95:64] !== e.c2) report("col_two", o_m_tdata[95:64], e.c2);
                    if (o_m_tdata[127:96] !== e.c3)
                        report("col_three", o_m_tdata[127:96], e.c3);
                    if (o_m_tlast !== e.last) report("last_row", 32'(o_m_tlast), 32'(e.last));
                end
                rows_seen++;
            end
            if (hold_off > 1) begin
                i_m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                i_m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                i_m_tready <= 1'b1;
                if (o_m_tvalid && i_m_tready)
                    recv_gap <= (rows_seen % 200 < 80) ? 0 : $urandom_range(0, 19);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("trs_model_matrix_top: mismatch");
            $finish;
        end
    end

    initial begin
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        wait (pending_items.size() == 0 && !i_s_tvalid);
        wait (rows_due.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("sent %0d transforms, checked %0d rows, %0d errors",
                 items_sent, rows_seen, errors);
        $display("covered angle wrap, saturated scales and a long output stall");
        if (errors == 0 && rows_due.size() == 0)
            $display("trs_model_matrix_top: match");
        else
            $display("trs_model_matrix_top: mismatch");
        $finish;
    end
endmodule
